@@ rtl/mtt_pkg.sv @@
package mtt_pkg;

    // Token kinds
    localparam logic [3:0] KIND_STRING = 4'd0;
    localparam logic [3:0] KIND_NUMBER = 4'd1;
    localparam logic [3:0] KIND_IDENT  = 4'd2;
    localparam logic [3:0] KIND_LPAREN = 4'd3;
    localparam logic [3:0] KIND_RPAREN = 4'd4;
    localparam logic [3:0] KIND_LBRACE = 4'd5;
    localparam logic [3:0] KIND_RBRACE = 4'd6;
    localparam logic [3:0] KIND_END    = 4'd7;
    localparam logic [3:0] KIND_ERROR  = 4'd8;

    // Characters
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    // Token queue geometry
    localparam int TQ_DEPTH = 8;
    localparam int TQ_AW    = 3;
    localparam int TQ_CW    = 4;

    // Most tokens one byte can produce
    localparam int MAX_TOKS = 3;

    typedef struct packed {
        logic [3:0]  kind;
        logic [15:0] start;
        logic [15:0] length;
        logic        last;
    } tok_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A))
            || (c == CH_UNDER);
    endfunction

endpackage

@@ rtl/mtt_scan.sv @@
module mtt_scan
    import mtt_pkg::*;
#(
    parameter int OFFSET_BITS = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  logic [7:0]          c,
    output tok_t [MAX_TOKS-1:0] toks,
    output logic [1:0]          tok_cnt
);

    localparam int OB = OFFSET_BITS;

    localparam logic [2:0] M_IDLE    = 3'd0;
    localparam logic [2:0] M_SLASH   = 3'd1;
    localparam logic [2:0] M_COMMENT = 3'd2;
    localparam logic [2:0] M_STRING  = 3'd3;
    localparam logic [2:0] M_NUMINT  = 3'd4;
    localparam logic [2:0] M_NUMDOT  = 3'd5;
    localparam logic [2:0] M_NUMFRAC = 3'd6;
    localparam logic [2:0] M_IDENT   = 3'd7;

    logic [2:0]    mode_reg, mode_next;
    logic [OB-1:0] pos_reg, pos_next;
    logic [OB-1:0] tbeg_reg, tbeg_next;
    logic [OB-1:0] mark_reg, mark_next;
    logic          do_start;
    tok_t [MAX_TOKS-1:0] toks_v;
    logic [1:0]    n_v;

    // Offset to 16-bit field (zero extend or truncate)
    function automatic logic [15:0] to16(input logic [OB-1:0] v);
        logic [OB+15:0] w;
        w = {16'd0, v};
        return w[15:0];
    endfunction

    // Clamped difference, reported on 16 bits
    function automatic logic [15:0] span(input logic [OB-1:0] from, input logic [OB:0] upto);
        logic [OB:0]    d;
        logic [OB+16:0] w;
        d = upto - {1'b0, from};
        w = {16'd0, d};
        return (upto >= {1'b0, from}) ? w[15:0] : 16'd0;
    endfunction

    function automatic tok_t mk_tok(input logic [3:0] k, input logic [15:0] s,
                                    input logic [15:0] l);
        tok_t t;
        t.kind   = k;
        t.start  = s;
        t.length = l;
        t.last   = 1'b0;
        return t;
    endfunction

    always_comb
    begin
        mode_next = M_IDLE;
        tbeg_next = tbeg_reg;
        mark_next = mark_reg;
        do_start  = 1'b0;
        toks_v    = '0;
        n_v       = 2'd0;

        // Close or continue the token in flight
        unique case (mode_reg)
            M_SLASH:
            begin
                if (c == CH_SLASH)
                    mode_next = M_COMMENT;
                else
                begin
                    tbeg_next = mark_reg;
                    toks_v[n_v] = mk_tok(KIND_ERROR, to16(mark_reg), 16'd1);
                    n_v = n_v + 2'd1;
                    do_start = 1'b1;
                end
            end
            M_COMMENT:
            begin
                if (c == CH_NUL)
                    do_start = 1'b1;
                else if (c != CH_LF)
                    mode_next = M_COMMENT;
            end
            M_STRING:
            begin
                if (c == CH_QUOTE)
                begin
                    toks_v[n_v] = mk_tok(KIND_STRING, to16(tbeg_reg),
                                         span(tbeg_reg, {1'b0, pos_reg} + 1'b1));
                    n_v = n_v + 2'd1;
                end
                else if (c == CH_NUL)
                    do_start = 1'b1;
                else
                    mode_next = M_STRING;
            end
            M_NUMINT:
            begin
                if (is_digit(c))
                    mode_next = M_NUMINT;
                else if (c == CH_DOT)
                begin
                    mark_next = pos_reg;
                    mode_next = M_NUMDOT;
                end
                else
                begin
                    toks_v[n_v] = mk_tok(KIND_NUMBER, to16(tbeg_reg),
                                         span(tbeg_reg, {1'b0, pos_reg}));
                    n_v = n_v + 2'd1;
                    do_start = 1'b1;
                end
            end
            M_NUMDOT:
            begin
                if (is_digit(c))
                    mode_next = M_NUMFRAC;
                else
                begin
                    // number ends before the dot, dot itself is an error
                    toks_v[n_v] = mk_tok(KIND_NUMBER, to16(tbeg_reg),
                                         span(tbeg_reg, {1'b0, mark_reg}));
                    n_v = n_v + 2'd1;
                    tbeg_next = mark_reg;
                    toks_v[n_v] = mk_tok(KIND_ERROR, to16(mark_reg), 16'd1);
                    n_v = n_v + 2'd1;
                    do_start = 1'b1;
                end
            end
            M_NUMFRAC:
            begin
                if (is_digit(c))
                    mode_next = M_NUMFRAC;
                else
                begin
                    toks_v[n_v] = mk_tok(KIND_NUMBER, to16(tbeg_reg),
                                         span(tbeg_reg, {1'b0, pos_reg}));
                    n_v = n_v + 2'd1;
                    do_start = 1'b1;
                end
            end
            M_IDENT:
            begin
                if (is_letter(c) || is_digit(c))
                    mode_next = M_IDENT;
                else
                begin
                    toks_v[n_v] = mk_tok(KIND_IDENT, to16(tbeg_reg),
                                         span(tbeg_reg, {1'b0, pos_reg}));
                    n_v = n_v + 2'd1;
                    do_start = 1'b1;
                end
            end
            default:
                do_start = 1'b1;
        endcase

        // Begin a new token with this byte
        if (do_start)
        begin
            case (c) inside
                CH_SPACE, CH_TAB, CH_CR, CH_LF: ;
                CH_NUL:
                begin
                    toks_v[n_v] = mk_tok(KIND_END, to16(tbeg_next),
                                         span(tbeg_next, {1'b0, pos_reg}));
                    n_v = n_v + 2'd1;
                end
                CH_SLASH:
                begin
                    mark_next = pos_reg;
                    mode_next = M_SLASH;
                end
                CH_LPAREN, CH_RPAREN, CH_LBRACE, CH_RBRACE:
                begin
                    tbeg_next = pos_reg;
                    case (c)
                        CH_LPAREN: toks_v[n_v] = mk_tok(KIND_LPAREN, to16(pos_reg), 16'd1);
                        CH_RPAREN: toks_v[n_v] = mk_tok(KIND_RPAREN, to16(pos_reg), 16'd1);
                        CH_LBRACE: toks_v[n_v] = mk_tok(KIND_LBRACE, to16(pos_reg), 16'd1);
                        default:   toks_v[n_v] = mk_tok(KIND_RBRACE, to16(pos_reg), 16'd1);
                    endcase
                    n_v = n_v + 2'd1;
                end
                default:
                begin
                    tbeg_next = pos_reg;
                    if (c == CH_QUOTE)
                        mode_next = M_STRING;
                    else if (is_digit(c) || (c == CH_MINUS))
                        mode_next = M_NUMINT;
                    else if (is_letter(c))
                        mode_next = M_IDENT;
                    else
                    begin
                        toks_v[n_v] = mk_tok(KIND_ERROR, to16(pos_reg), 16'd1);
                        n_v = n_v + 2'd1;
                    end
                end
            endcase
        end

        if (n_v != 2'd0)
            toks_v[n_v - 2'd1].last = 1'b1;

        // End of input starts a fresh document
        if (c == CH_NUL)
        begin
            mode_next = M_IDLE;
            tbeg_next = '0;
            mark_next = '0;
            pos_next  = '0;
        end
        else
            pos_next = (&pos_reg) ? pos_reg : pos_reg + 1'b1;
    end

    assign toks    = toks_v;
    assign tok_cnt = step ? n_v : 2'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= M_IDLE;
            pos_reg  <= '0;
            tbeg_reg <= '0;
            mark_reg <= '0;
        end
        else if (step)
        begin
            mode_reg <= mode_next;
            pos_reg  <= pos_next;
            tbeg_reg <= tbeg_next;
            mark_reg <= mark_next;
        end
    end

endmodule

@@ rtl/mtt_tokq.sv @@
module mtt_tokq
    import mtt_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  tok_t [MAX_TOKS-1:0] push_toks,
    input  logic [1:0]          push_cnt,
    output logic                room,
    output logic                pop_valid,
    input  logic                pop_ready,
    output tok_t                pop_tok
);

    // Room for a full burst of tokens from one byte
    localparam logic [TQ_CW-1:0] ROOM_LIMIT = TQ_CW'(TQ_DEPTH - MAX_TOKS);

    tok_t [TQ_DEPTH-1:0] mem_reg;
    logic [TQ_AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [TQ_AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [TQ_CW-1:0]    cnt_reg, cnt_next;
    logic                pop;

    assign pop       = pop_valid && pop_ready;
    assign pop_valid = (cnt_reg != '0);
    assign pop_tok   = mem_reg[rd_ptr_reg];
    assign room      = (cnt_reg <= ROOM_LIMIT);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + TQ_AW'(push_cnt);
        rd_ptr_next = rd_ptr_reg + TQ_AW'(pop);
        cnt_next    = cnt_reg + TQ_CW'(push_cnt) - TQ_CW'(pop);
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < MAX_TOKS; k++)
        begin
            if (k < int'(push_cnt))
                mem_reg[wr_ptr_reg + TQ_AW'(k)] <= push_toks[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

@@ rtl/map_text_tokenizer.sv @@
// map_text_tokenizer: streaming lexer, one document byte per transaction.
//
// Input channel (text_valid/text_ready/text_byte): one character per
// transaction; a zero byte ends the document and the next byte starts a new
// one at offset zero. Output channel (token_valid/token_ready/token_*): one
// token per transaction with kind, start offset and length; last_of_run
// marks the final token caused by one input byte. A byte yields zero to three
// tokens.
//
// Path: a byte accepted into the byte register is scanned from there, and
// its tokens go into the token queue, which offers them on the output.
// Throughput: one byte per cycle while the output keeps up; the output
// drains one token per cycle while token_ready is high, so bytes that cause
// several tokens fill the queue and can hold the input back.
// Reset clears the scan state, the byte offset and the token queue.
// When the receiver stalls, tokens collect in an 8-entry queue; the byte
// register holds its byte, and text_ready drops, once fewer than three queue
// slots are free.
module map_text_tokenizer
    import mtt_pkg::*;
#(
    parameter int OFFSET_BITS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        text_valid,
    output logic        text_ready,
    input  logic [7:0]  text_byte,
    output logic        token_valid,
    input  logic        token_ready,
    output logic [3:0]  token_kind,
    output logic [15:0] token_start,
    output logic [15:0] token_length,
    output logic        last_of_run
);

    logic                byte_valid_reg;
    logic [7:0]          byte_reg;
    logic                step;
    logic                room;
    tok_t [MAX_TOKS-1:0] toks;
    logic [1:0]          tok_cnt;
    tok_t                out_tok;

    // Byte register advances into the scanner when the queue has room
    assign step       = byte_valid_reg && room;
    assign text_ready = !byte_valid_reg || step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            byte_valid_reg <= 1'b0;
        else if (text_ready)
            byte_valid_reg <= text_valid;
    end

    always_ff @(posedge clk)
    begin
        if (text_ready && text_valid)
            byte_reg <= text_byte;
    end

    // Scanner: state machine plus token assembly for one byte
    mtt_scan #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_scan (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .c       (byte_reg),
        .toks    (toks),
        .tok_cnt (tok_cnt)
    );

    // Token queue serializes bursts onto the output
    mtt_tokq u_tokq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_toks (toks),
        .push_cnt  (tok_cnt),
        .room      (room),
        .pop_valid (token_valid),
        .pop_ready (token_ready),
        .pop_tok   (out_tok)
    );

    assign token_kind   = out_tok.kind;
    assign token_start  = out_tok.start;
    assign token_length = out_tok.length;
    assign last_of_run  = out_tok.last;

endmodule

@@ bench/tb.sv @@
module tb;
    import mtt_pkg::*;

    // Clock, reset and run control
    localparam int CLK_PERIOD     = 12;
    localparam int RESET_CYCLES   = 10;
    localparam int OFFSET_BITS    = 16;
    localparam int RAND_ITEMS     = 240;
    localparam int DRAIN_CYCLES   = 16;     // settle time after the last expected token is taken
    localparam int WATCHDOG_LIMIT = 1000;   // cycles with no transaction on either side

    localparam logic [63:0] POS_MAX = (64'd1 << OFFSET_BITS) - 64'd1;

    // Lexer modes of the local model
    typedef enum logic [2:0] {
        SC_IDLE,
        SC_SLASH,
        SC_COMMENT,
        SC_STRING,
        SC_NUMINT,
        SC_NUMDOT,
        SC_NUMFRAC,
        SC_IDENT
    } scan_e;

    // One row of the directed script. When fixed is set, the expected tokens
    // are typed in (count is 0 or 1); otherwise the local model supplies them.
    typedef struct packed {
        logic [7:0]  ch;
        logic        fixed;
        logic [1:0]  count;
        logic [3:0]  kind;
        logic [15:0] start;
        logic [15:0] length;
    } script_row_t;

    localparam int N_SCRIPT = 28;

    script_row_t script [N_SCRIPT] = '{
        '{"(",      1, 1, KIND_LPAREN, 0,  1},
        '{")",      1, 1, KIND_RPAREN, 1,  1},
        '{"{",      1, 1, KIND_LBRACE, 2,  1},
        '{"}",      1, 1, KIND_RBRACE, 3,  1},
        '{8'hFF,    1, 1, KIND_ERROR,  4,  1},
        '{CH_MINUS, 1, 0, KIND_ERROR,  0,  0},
        // a minus with no digits closes as a one-byte number
        '{CH_SPACE, 1, 1, KIND_NUMBER, 5,  1},
        '{"9",      0, 0, KIND_ERROR,  0,  0},
        '{CH_DOT,   0, 0, KIND_ERROR,  0,  0},
        '{"0",      0, 0, KIND_ERROR,  0,  0},
        '{CH_UNDER, 0, 0, KIND_ERROR,  0,  0},
        '{"Z",      0, 0, KIND_ERROR,  0,  0},
        '{CH_SLASH, 0, 0, KIND_ERROR,  0,  0},
        // lone slash, then a fresh identifier
        '{"a",      0, 0, KIND_ERROR,  0,  0},
        '{CH_DOT,   0, 0, KIND_ERROR,  0,  0},
        '{"0",      0, 0, KIND_ERROR,  0,  0},
        '{CH_DOT,   0, 0, KIND_ERROR,  0,  0},
        // dot without digit: number, error, brace from one byte
        '{CH_RBRACE,0, 0, KIND_ERROR,  0,  0},
        '{CH_SLASH, 0, 0, KIND_ERROR,  0,  0},
        '{CH_SLASH, 0, 0, KIND_ERROR,  0,  0},
        '{8'h80,    0, 0, KIND_ERROR,  0,  0},
        '{CH_LF,    0, 0, KIND_ERROR,  0,  0},
        '{CH_QUOTE, 0, 0, KIND_ERROR,  0,  0},
        '{"z",      0, 0, KIND_ERROR,  0,  0},
        '{CH_QUOTE, 0, 0, KIND_ERROR,  0,  0},
        '{CH_QUOTE, 0, 0, KIND_ERROR,  0,  0},
        // unterminated string: only the end token
        '{CH_NUL,   1, 1, KIND_END,    25, 1},
        // new document right after end of input starts at offset zero
        '{CH_NUL,   1, 1, KIND_END,    0,  0}
    };

    logic        clk = 1'b0;
    logic        rst_n;
    logic        text_valid;
    logic        text_ready;
    logic [7:0]  text_byte;
    logic        token_valid;
    logic        token_ready;
    logic [3:0]  token_kind;
    logic [15:0] token_start;
    logic [15:0] token_length;
    logic        last_of_run;

    // Local lexer state
    scan_e       scan_st  = SC_IDLE;
    logic [63:0] pos_q    = '0;
    logic [63:0] begin_q  = '0;
    logic [63:0] mark_q   = '0;
    tok_t        toks [MAX_TOKS];
    int          n_toks;

    tok_t        expected_tokens [$];
    int          err_count   = 0;
    int          rand_items  = 0;
    int          idle_cycles = 0;
    bit          tx_quiet    = 1'b0;
    bit          rx_quiet    = 1'b0;
    int          rx_stall    = 0;
    int          rx_cycle    = 0;
    tok_t        got_tok;
    tok_t        want_tok;

    map_text_tokenizer #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .text_valid   (text_valid),
        .text_ready   (text_ready),
        .text_byte    (text_byte),
        .token_valid  (token_valid),
        .token_ready  (token_ready),
        .token_kind   (token_kind),
        .token_start  (token_start),
        .token_length (token_length),
        .last_of_run  (last_of_run)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // ------------------------------------------------------------------
    // Local lexer model
    // ------------------------------------------------------------------

    function automatic bit ch_digit(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic bit ch_word(input logic [7:0] c);
        return ((c >= "A") && (c <= "Z")) || ((c >= "a") && (c <= "z")) || (c == CH_UNDER);
    endfunction

    // distance that never goes negative
    function automatic logic [63:0] span_of(input logic [63:0] from_p, input logic [63:0] to_p);
        return (to_p >= from_p) ? to_p - from_p : 64'd0;
    endfunction

    task automatic add_tok(input logic [3:0] kind, input logic [63:0] start,
                           input logic [63:0] length);
        if (n_toks < MAX_TOKS) begin
            toks[n_toks] = '{kind, start[15:0], length[15:0], 1'b0};
            n_toks++;
        end
    endtask

    // What a byte does when no token is open
    task automatic open_token(input logic [7:0] c, input logic [63:0] p);
        logic [3:0] kind;
        bit         bracket;
        bracket = 1'b1;
        kind    = KIND_ERROR;
        case (c)
            CH_SPACE, CH_TAB, CH_CR, CH_LF: return;
            CH_NUL:
            begin
                add_tok(KIND_END, begin_q, span_of(begin_q, p));
                return;
            end
            CH_SLASH:
            begin
                mark_q  = p;
                scan_st = SC_SLASH;
                return;
            end
            CH_LPAREN: kind = KIND_LPAREN;
            CH_RPAREN: kind = KIND_RPAREN;
            CH_LBRACE: kind = KIND_LBRACE;
            CH_RBRACE: kind = KIND_RBRACE;
            default:   bracket = 1'b0;
        endcase
        begin_q = p;
        if (bracket)
            add_tok(kind, p, 64'd1);
        else if (c == CH_QUOTE)
            scan_st = SC_STRING;
        else if (ch_digit(c) || c == CH_MINUS)
            scan_st = SC_NUMINT;
        else if (ch_word(c))
            scan_st = SC_IDENT;
        else
            add_tok(KIND_ERROR, p, 64'd1);
    endtask

    // Advance the model by one byte; tokens land in toks[0 .. n_toks-1].
    task automatic lex_byte(input logic [7:0] c);
        logic [63:0] p;
        scan_e       mode;
        p       = pos_q;
        mode    = scan_st;
        n_toks  = 0;
        scan_st = SC_IDLE;
        case (mode)
            SC_SLASH:
                if (c == CH_SLASH)
                    scan_st = SC_COMMENT;
                else
                begin
                    begin_q = mark_q;
                    add_tok(KIND_ERROR, mark_q, 64'd1);
                    open_token(c, p);
                end
            SC_COMMENT:
                if (c == CH_NUL)
                    open_token(c, p);
                else if (c != CH_LF)
                    scan_st = SC_COMMENT;
            SC_STRING:
                if (c == CH_QUOTE)
                    add_tok(KIND_STRING, begin_q, span_of(begin_q, p + 64'd1));
                else if (c == CH_NUL)
                    open_token(c, p);
                else
                    scan_st = SC_STRING;
            SC_NUMINT:
                if (ch_digit(c))
                    scan_st = SC_NUMINT;
                else if (c == CH_DOT)
                begin
                    mark_q  = p;
                    scan_st = SC_NUMDOT;
                end
                else
                begin
                    add_tok(KIND_NUMBER, begin_q, span_of(begin_q, p));
                    open_token(c, p);
                end
            SC_NUMDOT:
                if (ch_digit(c))
                    scan_st = SC_NUMFRAC;
                else
                begin
                    // number stops before the dot, the dot itself is an error
                    add_tok(KIND_NUMBER, begin_q, span_of(begin_q, mark_q));
                    begin_q = mark_q;
                    add_tok(KIND_ERROR, mark_q, 64'd1);
                    open_token(c, p);
                end
            SC_NUMFRAC:
                if (ch_digit(c))
                    scan_st = SC_NUMFRAC;
                else
                begin
                    add_tok(KIND_NUMBER, begin_q, span_of(begin_q, p));
                    open_token(c, p);
                end
            SC_IDENT:
                if (ch_word(c) || ch_digit(c))
                    scan_st = SC_IDENT;
                else
                begin
                    add_tok(KIND_IDENT, begin_q, span_of(begin_q, p));
                    open_token(c, p);
                end
            default:
                open_token(c, p);
        endcase

        // end of input wipes everything; otherwise the offset saturates
        if (c == CH_NUL)
        begin
            scan_st = SC_IDLE;
            pos_q   = '0;
            begin_q = '0;
            mark_q  = '0;
        end
        else
            pos_q = (p < POS_MAX) ? p + 64'd1 : POS_MAX;

        if (n_toks > 0)
            toks[n_toks - 1].last = 1'b1;
    endtask

    task automatic push_predicted();
        for (int i = 0; i < n_toks; i++)
            expected_tokens.push_back(toks[i]);
    endtask

    // ------------------------------------------------------------------
    // Byte sender
    // ------------------------------------------------------------------

    // Mostly back to back, some short gaps, rarely a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (tx_quiet || r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 8);
        else
            return $urandom_range(20, 40);
    endfunction

    // Drive one byte at the falling edge and hold it until a rising edge
    // sees text_ready. Returns at the falling edge after the transaction,
    // with text_valid still high.
    task automatic feed(input logic [7:0] c);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            text_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        text_valid = 1'b1;
        text_byte  = c;
        @(posedge clk);
        while (!text_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic put(input logic [7:0] c, input bit counted);
        feed(c);
        lex_byte(c);
        push_predicted();
        if (counted)
            rand_items++;
    endtask

    // Sender holds off until every expected token has been taken.
    task automatic hold_until_drained();
        text_valid = 1'b0;
        wait (expected_tokens.size() == 0);
        @(negedge clk);
    endtask

    // ------------------------------------------------------------------
    // Random document pieces
    // ------------------------------------------------------------------

    function automatic logic [7:0] pick_letter();
        int r;
        r = $urandom_range(0, 52);
        if (r < 26)
            return 8'("A" + r);
        else if (r < 52)
            return 8'("a" + r - 26);
        else
            return CH_UNDER;
    endfunction

    function automatic logic [7:0] pick_alnum();
        if ($urandom_range(0, 3) == 0)
            return 8'("0" + $urandom_range(0, 9));
        else
            return pick_letter();
    endfunction

    function automatic logic [7:0] pick_digit();
        return 8'("0" + $urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] pick_bracket();
        case ($urandom_range(0, 3))
            0:       return CH_LPAREN;
            1:       return CH_RPAREN;
            2:       return CH_LBRACE;
            default: return CH_RBRACE;
        endcase
    endfunction

    // any byte that keeps a string open
    function automatic logic [7:0] pick_string_byte();
        logic [7:0] c;
        c = 8'($urandom_range(1, 255));
        return (c == CH_QUOTE) ? "x" : c;
    endfunction

    task automatic put_space();
        case ($urandom_range(0, 3))
            0:       put(CH_SPACE, 0);
            1:       put(CH_TAB, 0);
            2:       put(CH_CR, 0);
            default: put(CH_LF, 0);
        endcase
    endtask

    task automatic put_number();
        int n_digits;
        bit minus;
        minus    = $urandom_range(0, 2) == 0;
        n_digits = $urandom_range(minus ? 0 : 1, 4);
        if (minus)
            put(CH_MINUS, 1);
        repeat (n_digits) put(pick_digit(), 1);
        if ($urandom_range(0, 4) < 2)
        begin
            put(CH_DOT, 1);
            repeat ($urandom_range(0, 3)) put(pick_digit(), 1);
        end
    endtask

    task automatic put_comment();
        logic [7:0] c;
        put(CH_SLASH, 1);
        put(CH_SLASH, 1);
        repeat ($urandom_range(0, 6))
        begin
            c = 8'($urandom_range(1, 255));
            put((c == CH_LF) ? "c" : c, 0);
        end
        // a comment may also run into end of input
        if ($urandom_range(0, 3) == 0)
            put(CH_NUL, 1);
        else
            put(CH_LF, 0);
    endtask

    // One document with random content; a few stay open or end
    // inside a string.
    task automatic gen_document();
        int n_elem;
        int r;
        tx_quiet = ($urandom_range(0, 5) == 0);
        n_elem   = $urandom_range(1, 8);
        for (int e = 0; e < n_elem; e++)
        begin
            if ($urandom_range(0, 1) == 0)
                put_space();
            case ($urandom_range(0, 9))
                0, 1:
                begin
                    put(pick_letter(), 1);
                    repeat ($urandom_range(0, 5)) put(pick_alnum(), 1);
                end
                2, 3: put_number();
                4:
                begin
                    put(CH_QUOTE, 1);
                    repeat ($urandom_range(0, 5)) put(pick_string_byte(), 1);
                    put(CH_QUOTE, 1);
                end
                5: put(pick_bracket(), 1);
                6: put_comment();
                7: put(CH_SLASH, 1);
                8: put(CH_DOT, 1);
                default:
                    repeat ($urandom_range(1, 5)) put(8'($urandom_range(0, 255)), 1);
            endcase
        end
        r = $urandom_range(0, 19);
        if (r < 2)
        begin
            put(CH_QUOTE, 1);
            repeat ($urandom_range(0, 4)) put(pick_string_byte(), 1);
            put(CH_NUL, 1);
        end
        else if (r < 18)
            put(CH_NUL, 1);
    endtask

    // ------------------------------------------------------------------
    // Token receiver: random back-pressure with quiet stretches
    // ------------------------------------------------------------------

    function automatic int pick_stall();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 40);
    endfunction

    initial
    begin
        token_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            rx_cycle++;
            if (rx_cycle % 200 == 0)
                rx_quiet = ($urandom_range(0, 2) == 0);
            if (rx_stall > 0)
            begin
                token_ready = 1'b0;
                rx_stall--;
            end
            else
            begin
                token_ready = 1'b1;
                if (!rx_quiet)
                    rx_stall = pick_stall();
            end
        end
    end

    // ------------------------------------------------------------------
    // Token checker: every transaction against the oldest expectation
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin
        if (rst_n && token_valid && token_ready)
        begin
            got_tok = '{token_kind, token_start, token_length, last_of_run};
            if (expected_tokens.size() == 0)
            begin
                $display("%0t: unexpected token, expected none, got kind %0d start %0d",
                         $time, got_tok.kind, got_tok.start);
                $display("%0t: unexpected token len %0d last %0d",
                         $time, got_tok.length, got_tok.last);
                err_count++;
            end
            else
            begin
                want_tok = expected_tokens.pop_front();
                if (got_tok.kind !== want_tok.kind)
                begin
                    $display("%0t: token_kind expected %0d, got %0d",
                             $time, want_tok.kind, got_tok.kind);
                    err_count++;
                end
                if (got_tok.start !== want_tok.start)
                begin
                    $display("%0t: token_start expected %0d, got %0d",
                             $time, want_tok.start, got_tok.start);
                    err_count++;
                end
                if (got_tok.length !== want_tok.length)
                begin
                    $display("%0t: token_length expected %0d, got %0d",
                             $time, want_tok.length, got_tok.length);
                    err_count++;
                end
                if (got_tok.last !== want_tok.last)
                begin
                    $display("%0t: last_of_run expected %0d, got %0d",
                             $time, want_tok.last, got_tok.last);
                    err_count++;
                end
            end
        end
    end

    // Watchdog: too long without a transaction on either channel
    always @(posedge clk)
    begin
        if (!rst_n || (text_valid && text_ready) || (token_valid && token_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial
    begin
        rst_n      = 1'b0;
        text_valid = 1'b0;
        text_byte  = 8'h00;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;

        // Directed script: brackets, extremes, lone minus, fraction, lone
        // slash, dot without digit, comment, string, unterminated string,
        // and a fresh document after end of input.
        for (int i = 0; i < N_SCRIPT; i++)
        begin
            feed(script[i].ch);
            lex_byte(script[i].ch);
            if (script[i].fixed)
            begin
                if (script[i].count != 0)
                    expected_tokens.push_back('{script[i].kind, script[i].start,
                                                script[i].length, 1'b1});
            end
            else
                push_predicted();
        end

        // Sender waits for the output to empty before the random documents.
        hold_until_drained();

        // Random documents, with an occasional full drain in between
        rand_items = 0;
        while (rand_items < RAND_ITEMS)
        begin
            if ($urandom_range(0, 14) == 0)
                hold_until_drained();
            gen_document();
        end
        text_valid = 1'b0;

        wait (expected_tokens.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (err_count == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule

@@ map_text_tokenizer.f @@
rtl/mtt_pkg.sv
rtl/mtt_scan.sv
rtl/mtt_tokq.sv
rtl/map_text_tokenizer.sv
bench/tb.sv
